// ===== rtl/smrte_pkg.sv =====
// ----------------------------------------------------------------------------
// smrte_pkg
// shared types and constants of the staged mixed-radix tuple enumerator
// ----------------------------------------------------------------------------
package smrte_pkg;

	localparam int DEF_INDEX_WIDTH = 16;
	localparam int DEF_MAX_DIGITS  = 4;
	localparam int DIGIT_SLOTS     = 4;
	localparam int STAGE_FIELD_W   = 18;
	localparam int IN_TDATA_W      = 8;
	localparam int CFG_INDEX_W     = 3;
	localparam int PTR_W           = 3;

	// request opcodes
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_NEXT  = 2'd1;
	localparam logic [1:0] OP_FAIL  = 2'd2;

	// configuration register indexes
	localparam logic [2:0] REG_COUNT0 = 3'd0;
	localparam logic [2:0] REG_COUNT1 = 3'd1;
	localparam logic [2:0] REG_COUNT2 = 3'd2;
	localparam logic [2:0] REG_COUNT3 = 3'd3;
	localparam logic [2:0] REG_DIGITS = 3'd4;
	localparam logic [2:0] REG_SUM    = 3'd5;
	localparam logic [2:0] REG_EMPTY  = 3'd6;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_MASK,
		CMD_START,
		CMD_SCAN,
		CMD_SA_INIT,
		CMD_SA,
		CMD_FILL_B,
		CMD_FILL_R,
		CMD_MA_INIT,
		CMD_MA,
		CMD_MC,
		CMD_MS,
		CMD_MR,
		CMD_FIN
	} cmd_t;

	typedef struct packed {
		cmd_t op;
		logic ok;
	} ctl_cmd_t;

	typedef struct packed {
		logic live;
		logic sa_hit;
		logic fill_more;
		logic suffix_zero;
		logic ma_hit;
		logic in_stage;
		logic ms_hit;
		logic mr_over;
		logic out_free;
		logic more;
		logic sum_mode;
	} dp_status_t;

	function automatic int out_tdata_w(input int w);
		return ((1 + DIGIT_SLOTS * w + STAGE_FIELD_W + 7) / 8) * 8;
	endfunction

endpackage

// ===== rtl/smrte_dp.sv =====
// ----------------------------------------------------------------------------
// smrte_dp
// datapath: config registers, digit registers, stage state, result register
// ----------------------------------------------------------------------------
module smrte_dp #(
	parameter int INDEX_WIDTH = smrte_pkg::DEF_INDEX_WIDTH,
	parameter int MAX_DIGITS  = smrte_pkg::DEF_MAX_DIGITS
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  smrte_pkg::ctl_cmd_t                             cmd,
	output smrte_pkg::dp_status_t                           status,
	input  logic [3:0]                                      fail_mask,
	input  logic                                            cfg_we,
	input  logic [smrte_pkg::CFG_INDEX_W-1:0]               cfg_index,
	input  logic [INDEX_WIDTH-1:0]                          cfg_data,
	input  logic                                            m_tready,
	output logic                                            m_tvalid,
	output logic [smrte_pkg::out_tdata_w(INDEX_WIDTH)-1:0]  m_tdata
);
	import smrte_pkg::*;

	localparam int W     = INDEX_WIDTH;
	localparam int SW    = INDEX_WIDTH + 2;
	localparam int OUT_W = out_tdata_w(INDEX_WIDTH);

	logic [W-1:0]      count_q [DIGIT_SLOTS];
	logic [2:0]        digits_q;
	logic              sum_q;
	logic              allow_q;

	logic [W-1:0]      dig_q [MAX_DIGITS];
	logic [W-1:0]      dig_d [MAX_DIGITS];
	logic [SW-1:0]     stage_q, stage_d;
	logic [SW-1:0]     suffix_q, suffix_d;
	logic [W-1:0]      limit_q, limit_d;
	logic [2:0]        prefix_q, prefix_d;
	logic              more_q, more_d;
	logic [PTR_W-1:0]  ptr_q, ptr_d;

	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;
	logic [OUT_W-1:0]  out_data_d;

	logic [2:0]        n_c;
	logic              live;
	logic [1:0]        cur;
	logic [W-1:0]      cnt_cur;
	logic [W-1:0]      dig_cur;
	logic [W-1:0]      top_cur;
	logic [W:0]        nv;
	logic [W-1:0]      fill_v;
	logic [2:0]        mask_p;
	logic              in_stage;
	logic              out_free;

	assign n_c     = (digits_q > 3'(MAX_DIGITS)) ? 3'(MAX_DIGITS) : digits_q;
	assign live    = (ptr_q != '0);
	assign cur     = 2'(ptr_q - 1'b1);
	assign cnt_cur = count_q[cur];
	assign top_cur = (cnt_cur == '0) ? '0 : cnt_cur - 1'b1;
	assign nv      = {1'b0, dig_cur} + 1'b1;
	assign fill_v  = (suffix_q < SW'(top_cur)) ? W'(suffix_q) : top_cur;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		dig_cur = '0;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (live && 2'(i) == cur) dig_cur = dig_q[i];
		end
	end

	always_comb begin
		in_stage = (stage_q <= SW'(1));
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (3'(i) < n_c && SW'(dig_q[i]) >= stage_q) in_stage = 1'b1;
		end
	end

	// highest marked digit inside the tuple, plus one
	always_comb begin
		mask_p = '0;
		for (int i = 0; i < DIGIT_SLOTS; i++) begin
			if (3'(i) < n_c && fail_mask[i]) mask_p = 3'(i + 1);
		end
	end

	always_comb begin
		status.live        = live;
		status.sa_hit      = (suffix_q != '0) && (nv < {1'b0, cnt_cur})
		                     && ({1'b0, cur} < prefix_q);
		status.fill_more   = (suffix_q != '0) && live;
		status.suffix_zero = (suffix_q == '0);
		status.ma_hit      = (nv < {1'b0, cnt_cur}) && ((SW + 1)'(nv) <= {1'b0, stage_q});
		status.in_stage    = in_stage;
		status.ms_hit      = (SW'(cnt_cur) > stage_q);
		status.mr_over     = ({1'b0, stage_q} + 1'b1 >= (SW + 1)'(limit_q));
		status.out_free    = out_free;
		status.more        = more_q;
		status.sum_mode    = sum_q;
	end

	always_comb begin
		dig_d    = dig_q;
		stage_d  = stage_q;
		suffix_d = suffix_q;
		limit_d  = limit_q;
		prefix_d = prefix_q;
		more_d   = more_q;
		ptr_d    = ptr_q;
		case (cmd.op)
			CMD_MASK: begin
				prefix_d = mask_p;
			end
			CMD_START: begin
				for (int i = 0; i < MAX_DIGITS; i++) dig_d[i] = '0;
				stage_d  = '0;
				prefix_d = n_c;
				more_d   = (n_c != '0);
				limit_d  = W'(1);
				ptr_d    = n_c;
			end
			CMD_SCAN: begin
				if (live) begin
					if (cnt_cur == '0 && !allow_q) more_d = 1'b0;
					if (cnt_cur > limit_q) limit_d = cnt_cur;
					ptr_d = ptr_q - 1'b1;
				end
			end
			CMD_SA_INIT: begin
				suffix_d = '0;
				ptr_d    = n_c;
			end
			CMD_SA: begin
				if (!live) begin
					// no carry left: set up the raise to the next sum
					suffix_d = stage_q + 1'b1;
					stage_d  = '0;
					ptr_d    = n_c;
					prefix_d = n_c;
				end else if (status.sa_hit) begin
					for (int i = 0; i < MAX_DIGITS; i++)
						if (2'(i) == cur) dig_d[i] = W'(nv);
					suffix_d = suffix_q - 1'b1;
					ptr_d    = n_c;
				end else begin
					for (int i = 0; i < MAX_DIGITS; i++)
						if (2'(i) == cur) dig_d[i] = '0;
					suffix_d = suffix_q + SW'(dig_cur);
					ptr_d    = ptr_q - 1'b1;
				end
			end
			CMD_FILL_B, CMD_FILL_R: begin
				if (status.fill_more) begin
					for (int i = 0; i < MAX_DIGITS; i++)
						if (2'(i) == cur) dig_d[i] = fill_v;
					suffix_d = suffix_q - SW'(fill_v);
					if (cmd.op == CMD_FILL_R) stage_d = stage_q + SW'(fill_v);
					ptr_d = ptr_q - 1'b1;
				end
			end
			CMD_MA_INIT: begin
				ptr_d = (prefix_q < n_c) ? prefix_q : n_c;
			end
			CMD_MA: begin
				if (live && status.ma_hit) begin
					for (int i = 0; i < MAX_DIGITS; i++) begin
						if (2'(i) == cur) dig_d[i] = W'(nv);
						if (3'(i) > {1'b0, cur} && 3'(i) < n_c) dig_d[i] = '0;
					end
				end else if (live) begin
					ptr_d = ptr_q - 1'b1;
				end
			end
			CMD_MC: begin
				ptr_d = n_c;
			end
			CMD_MS: begin
				if (live && status.ms_hit) begin
					for (int i = 0; i < MAX_DIGITS; i++) begin
						if (2'(i) == cur) dig_d[i] = W'(stage_q);
						if (3'(i) > {1'b0, cur} && 3'(i) < n_c) dig_d[i] = '0;
					end
				end else if (live) begin
					ptr_d = ptr_q - 1'b1;
				end
			end
			CMD_MR: begin
				prefix_d = n_c;
				stage_d  = stage_q + 1'b1;
				for (int i = 0; i < MAX_DIGITS; i++)
					if (3'(i) < n_c) dig_d[i] = '0;
				ptr_d = n_c;
			end
			CMD_FIN: begin
				if (out_free) more_d = cmd.ok;
			end
			default: begin
			end
		endcase
	end

	// result word, tuple_valid in bit 0
	always_comb begin
		out_data_d    = '0;
		out_data_d[0] = cmd.ok;
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (cmd.ok && 3'(i) < n_c) out_data_d[1 + i * W +: W] = dig_q[i];
		end
		if (cmd.ok)
			out_data_d[1 + DIGIT_SLOTS * W +: STAGE_FIELD_W] = STAGE_FIELD_W'(stage_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_SLOTS; i++) count_q[i] <= '0;
			digits_q <= '0;
			sum_q    <= 1'b0;
			allow_q  <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COUNT0: count_q[0] <= cfg_data;
				REG_COUNT1: count_q[1] <= cfg_data;
				REG_COUNT2: count_q[2] <= cfg_data;
				REG_COUNT3: count_q[3] <= cfg_data;
				REG_DIGITS: digits_q   <= cfg_data[2:0];
				REG_SUM:    sum_q      <= cfg_data[0];
				REG_EMPTY:  allow_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_DIGITS; i++) dig_q[i] <= '0;
			stage_q     <= '0;
			suffix_q    <= '0;
			limit_q     <= W'(1);
			prefix_q    <= 3'd4;
			more_q      <= 1'b0;
			ptr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			dig_q    <= dig_d;
			stage_q  <= stage_d;
			suffix_q <= suffix_d;
			limit_q  <= limit_d;
			prefix_q <= prefix_d;
			more_q   <= more_d;
			ptr_q    <= ptr_d;
			if (cmd.op == CMD_FIN && out_free) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == CMD_FIN && out_free) out_data_q <= out_data_d;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== rtl/smrte_ctrl.sv =====
// ----------------------------------------------------------------------------
// smrte_ctrl
// controller: sequences the digit walks of start and next requests
// ----------------------------------------------------------------------------
module smrte_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [1:0]            opcode,
	input  smrte_pkg::dp_status_t status,
	output smrte_pkg::ctl_cmd_t   cmd
);
	import smrte_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_SCAN = 11'b000_0000_0010,
		ST_SA   = 11'b000_0000_0100,
		ST_SB   = 11'b000_0000_1000,
		ST_SR   = 11'b000_0001_0000,
		ST_MA   = 11'b000_0010_0000,
		ST_MC   = 11'b000_0100_0000,
		ST_MS   = 11'b000_1000_0000,
		ST_MR   = 11'b001_0000_0000,
		ST_MRS  = 11'b010_0000_0000,
		ST_FIN  = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   ok_q, ok_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ok_d    = ok_q;
		cmd.op  = CMD_NONE;
		cmd.ok  = ok_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					case (opcode)
						OP_START: begin
							cmd.op  = CMD_START;
							state_d = ST_SCAN;
						end
						OP_NEXT: begin
							if (!status.more) begin
								ok_d    = 1'b0;
								state_d = ST_FIN;
							end else if (status.sum_mode) begin
								cmd.op  = CMD_SA_INIT;
								state_d = ST_SA;
							end else begin
								cmd.op  = CMD_MA_INIT;
								state_d = ST_MA;
							end
						end
						OP_FAIL: cmd.op = CMD_MASK;
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				cmd.op = CMD_SCAN;
				if (!status.live) begin
					ok_d    = status.more;
					state_d = ST_FIN;
				end
			end
			ST_SA: begin
				cmd.op = CMD_SA;
				if (!status.live) state_d = ST_SR;
				else if (status.sa_hit) state_d = ST_SB;
			end
			ST_SB: begin
				cmd.op = CMD_FILL_B;
				if (!status.fill_more) begin
					ok_d    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_SR: begin
				cmd.op = CMD_FILL_R;
				if (!status.fill_more) begin
					ok_d    = status.suffix_zero;
					state_d = ST_FIN;
				end
			end
			ST_MA: begin
				cmd.op = CMD_MA;
				if (!status.live) state_d = ST_MR;
				else if (status.ma_hit) state_d = ST_MC;
			end
			ST_MC: begin
				cmd.op = CMD_MC;
				if (status.in_stage) begin
					ok_d    = 1'b1;
					state_d = ST_FIN;
				end else begin
					state_d = ST_MS;
				end
			end
			ST_MS: begin
				cmd.op = CMD_MS;
				if (!status.live) begin
					state_d = ST_MR;
				end else if (status.ms_hit) begin
					ok_d    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_MR: begin
				cmd.op = CMD_MR;
				if (status.mr_over) begin
					ok_d    = 1'b0;
					state_d = ST_FIN;
				end else begin
					state_d = ST_MRS;
				end
			end
			ST_MRS: begin
				cmd.op = CMD_MS;
				if (!status.live) begin
					ok_d    = 1'b0;
					state_d = ST_FIN;
				end else if (status.ms_hit) begin
					ok_d    = 1'b1;
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.op = CMD_FIN;
				if (status.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ok_q    <= ok_d;
		end
	end

endmodule

// ===== rtl/staged_mixed_radix_tuple_enumerator.sv =====
// ----------------------------------------------------------------------------
// staged_mixed_radix_tuple_enumerator
// enumerates digit tuples stage by stage, by digit sum or by digit maximum
// ----------------------------------------------------------------------------
// One request is handled at a time and the digits are walked one per cycle,
// least significant in use first; the stage check of max mode compares all
// digits at once. A start request scans the digits in use, and a failure mask
// is taken without leaving idle. A next request in sum mode does a carry
// search, then refill of the lower digits, or refill at the next digit sum; in
// max mode a carry search, stage check, search for a digit that reaches the
// stage, and on a stage change a further search. A finished result sits in
// the output register, so a new request is taken while it waits.
// ----------------------------------------------------------------------------
module staged_mixed_radix_tuple_enumerator #(
	parameter int INDEX_WIDTH = smrte_pkg::DEF_INDEX_WIDTH,
	parameter int MAX_DIGITS  = smrte_pkg::DEF_MAX_DIGITS
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	// request channel
	input  logic                                            s_tvalid,
	output logic                                            s_tready,
	input  logic [smrte_pkg::IN_TDATA_W-1:0]                s_tdata,   // opcode, fail_mask
	// result channel
	output logic                                            m_tvalid,
	input  logic                                            m_tready,
	// tuple_valid, index_digit0..3, stage_number
	output logic [smrte_pkg::out_tdata_w(INDEX_WIDTH)-1:0]  m_tdata,
	// configuration writes
	input  logic                                            cfg_we,
	input  logic [smrte_pkg::CFG_INDEX_W-1:0]               cfg_index,
	input  logic [INDEX_WIDTH-1:0]                          cfg_data
);
	import smrte_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	// controller steps through the digit walks
	smrte_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.opcode   (s_tdata[1:0]),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath holds the counts, the digits and the result register
	smrte_dp #(
		.INDEX_WIDTH (INDEX_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.fail_mask (s_tdata[5:2]),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
